@@ sv/hse_pkg.sv @@
// hse_pkg: shared types, constants and helpers of the Huffman stream encoder.
// Used by hse_queue users, hse_front, hse_pack and huffman_stream_encoder.
// No dependencies.
`default_nettype none

package hse_pkg;

    // Fixed field widths of the item and result words
    localparam int SYMBOL_W   = 8;
    localparam int CODE_LEN_W = 5;
    localparam int CODE_W     = 16;
    localparam int OUT_W      = 32;

    // Parameter defaults
    localparam int SYMBOLS_DEF      = 256;
    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int WORD_BITS_DEF    = 32;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        func_t                 func;
        logic [SYMBOL_W-1:0]   symbol;
        logic [CODE_LEN_W-1:0] code_length;
        logic [CODE_W-1:0]     code_bits;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] packed_word;
        logic             final_word;
    } result_t;

    // Work handed from front to back: a resolved code or a flush
    typedef struct packed {
        logic                  flush;
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_W-1:0]     code;
    } cmd_t;

    // Longest code length the table can hold
    function automatic int len_cap(int max_len, int word_bits);
        int c;
        c = (max_len < word_bits) ? max_len : word_bits;
        return (c > (2**CODE_LEN_W - 1)) ? (2**CODE_LEN_W - 1) : c;
    endfunction

endpackage

`default_nettype wire

@@ sv/hse_queue.sv @@
// hse_queue: small first-in first-out queue of generic words.
// Depends on nothing; used by huffman_stream_encoder.
`default_nettype none

module hse_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           rdata,
    output logic                            empty,
    output logic                            full,
    output logic      [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign level   = count_reg;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/hse_front.sv @@
// hse_front: takes items, holds the code table, resolves encode and flush words.
// Depends on hse_pkg.
`default_nettype none

module hse_front #(
    parameter int SYMBOLS      = hse_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF,
    parameter int WORD_BITS    = hse_pkg::WORD_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     push,
    input  wire hse_pkg::item_t                           item,
    output logic                                          full,
    input  wire logic [$clog2(hse_pkg::CMD_DEPTH+1)-1:0]  cmd_level,
    output logic                                          cmd_push,
    output hse_pkg::cmd_t                                 cmd_data
);

    localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int LEN_MAX = hse_pkg::len_cap(MAX_CODE_LEN, WORD_BITS);
    localparam int QCW     = $clog2(hse_pkg::CMD_DEPTH+1);
    localparam int TAB_W   = hse_pkg::CODE_LEN_W + hse_pkg::CODE_W;

    logic [TAB_W-1:0]                tab_mem [SYMBOLS];
    logic [SYMBOLS-1:0]              tab_valid_reg;
    logic [TAB_W-1:0]                rd_data_reg;
    logic                            rd_hit_reg;
    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_flush_reg, s1_flush_next;

    logic                            accept, in_range;
    logic                            tab_we, tab_re;
    logic [SYM_W-1:0]                idx;
    logic [hse_pkg::CODE_LEN_W-1:0]  len_sat;
    logic [hse_pkg::CODE_W-1:0]      len_mask;
    logic [TAB_W-1:0]                tab_wdata;

    // One slot per word in flight: queue contents plus the read stage
    assign full     = (({1'b0, cmd_level} + (QCW+1)'(s1_valid_reg))
                       >= (QCW+1)'(hse_pkg::CMD_DEPTH));
    assign accept   = push && !full;
    assign idx      = item.symbol[SYM_W-1:0];
    assign in_range = ({1'b0, item.symbol} < (hse_pkg::SYMBOL_W+1)'(SYMBOLS));

    // Saturate length, drop code bits above it
    assign len_sat   = (item.code_length > hse_pkg::CODE_LEN_W'(LEN_MAX))
                       ? hse_pkg::CODE_LEN_W'(LEN_MAX) : item.code_length;
    assign len_mask  = hse_pkg::CODE_W'((32'd1 << len_sat) - 32'd1);
    assign tab_wdata = {len_sat, item.code_bits & len_mask};

    always_comb
    begin
        tab_we        = 1'b0;
        tab_re        = 1'b0;
        s1_valid_next = 1'b0;
        s1_flush_next = 1'b0;
        if (accept)
        begin
            unique case (item.func)
                hse_pkg::FUNC_LOAD:
                begin
                    tab_we = in_range;
                end
                hse_pkg::FUNC_ENCODE:
                begin
                    tab_re        = in_range;
                    s1_valid_next = in_range;
                end
                hse_pkg::FUNC_FLUSH:
                begin
                    s1_valid_next = 1'b1;
                    s1_flush_next = 1'b1;
                end
                hse_pkg::FUNC_NONE:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
            if (tab_we)
            begin
                tab_valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[idx] <= tab_wdata;
        end
        if (tab_re)
        begin
            rd_data_reg <= tab_mem[idx];
            rd_hit_reg  <= tab_valid_reg[idx];
        end
    end

    // Never-written entries read as length zero
    always_comb
    begin
        cmd_push       = s1_valid_reg;
        cmd_data.flush = s1_flush_reg;
        if (s1_flush_reg || !rd_hit_reg)
        begin
            cmd_data.len  = '0;
            cmd_data.code = '0;
        end
        else
        begin
            cmd_data.len  = rd_data_reg[TAB_W-1 -: hse_pkg::CODE_LEN_W];
            cmd_data.code = rd_data_reg[hse_pkg::CODE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ sv/hse_pack.sv @@
// hse_pack: bit accumulator; appends codes and cuts out full and flushed words.
// Depends on hse_pkg.
`default_nettype none

module hse_pack #(
    parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF,
    parameter int WORD_BITS    = hse_pkg::WORD_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_empty,
    input  wire hse_pkg::cmd_t     cmd_data,
    output logic                   cmd_pop,
    input  wire logic              res_full,
    output logic                   res_push,
    output hse_pkg::result_t       res_data
);

    localparam int LEN_MAX = hse_pkg::len_cap(MAX_CODE_LEN, WORD_BITS);
    localparam int ACC_W   = WORD_BITS - 1;
    localparam int CNT_W   = $clog2(WORD_BITS);
    localparam int COMB_W  = ACC_W + LEN_MAX;
    localparam int TOT_W   = $clog2(COMB_W + 1);

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [COMB_W-1:0]    combined;
    logic [TOT_W-1:0]     total, rem;
    logic                 emit;
    logic [CNT_W:0]       fl_shift;
    logic [WORD_BITS-1:0] word_emit, word_flush;

    assign cmd_pop  = !cmd_empty && !res_full;

    assign combined = (COMB_W'(acc_reg) << cmd_data.len) | COMB_W'(cmd_data.code);
    assign total    = TOT_W'(count_reg) + TOT_W'(cmd_data.len);
    assign emit     = (total >= TOT_W'(WORD_BITS));
    assign rem      = total - TOT_W'(WORD_BITS);
    assign word_emit = WORD_BITS'(combined >> rem);

    // Flush: held bits move to the top, zeros below
    assign fl_shift   = (CNT_W+1)'(WORD_BITS) - (CNT_W+1)'(count_reg);
    assign word_flush = WORD_BITS'(acc_reg) << fl_shift;

    always_comb
    begin
        acc_next             = acc_reg;
        count_next           = count_reg;
        res_push             = 1'b0;
        res_data.packed_word = hse_pkg::OUT_W'(word_emit);
        res_data.final_word  = 1'b0;
        if (cmd_pop)
        begin
            priority if (cmd_data.flush)
            begin
                acc_next             = '0;
                count_next           = '0;
                res_push             = 1'b1;
                res_data.packed_word = hse_pkg::OUT_W'(word_flush);
                res_data.final_word  = 1'b1;
            end
            else if (emit)
            begin
                acc_next   = ACC_W'(combined & ((COMB_W'(1) << rem) - COMB_W'(1)));
                count_next = CNT_W'(rem);
                res_push   = 1'b1;
            end
            else
            begin
                acc_next   = ACC_W'(combined);
                count_next = CNT_W'(total);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/huffman_stream_encoder.sv @@
// huffman_stream_encoder: top level of the Huffman stream encoder.
// Depends on hse_pkg, hse_queue, hse_front and hse_pack.
//
//   channel  | handshake        | word
//   ---------+------------------+---------------------------------------------
//   item     | push / full      | func, symbol, code_length, code_bits
//   result   | pop / empty      | packed_word, final_word
//
// Throughput: one item per cycle while full is low. A word reaches the result
// ports by way of the table read register, command queue and result queue.
// Reset: asynchronous, active low. A valid bit per table entry makes the table
// read as all zero right after reset; no clearing pass.
// Stalls: a held-off pop fills the result queue, then the command queue,
// then raises full, which holds off loads and ignored items as well.
`default_nettype none

module huffman_stream_encoder #(
    parameter int SYMBOLS      = hse_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF,
    parameter int WORD_BITS    = hse_pkg::WORD_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire hse_pkg::item_t    item,
    output logic                   empty,
    input  wire logic              pop,
    output hse_pkg::result_t       result
);

    localparam int CMD_CW = $clog2(hse_pkg::CMD_DEPTH+1);
    localparam int RES_CW = $clog2(hse_pkg::RES_DEPTH+1);

    // front -> command queue
    logic                 cmd_push;
    hse_pkg::cmd_t        cmd_wdata;
    // command queue -> back
    hse_pkg::cmd_t        cmd_rdata;
    logic                 cmd_empty, cmd_full, cmd_pop;
    logic [CMD_CW-1:0]    cmd_level;
    // back -> result queue
    logic                 res_push, res_full;
    hse_pkg::result_t     res_wdata;
    logic [RES_CW-1:0]    res_level;

    // Front: takes items, loads and reads the code table
    hse_front #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .WORD_BITS    (WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_level (cmd_level),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_wdata)
    );

    // Decouples table lookups from the accumulator
    hse_queue #(
        .WIDTH ($bits(hse_pkg::cmd_t)),
        .DEPTH (hse_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty),
        .full  (cmd_full),
        .level (cmd_level)
    );

    // Back: bit packing into output words
    hse_pack #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .WORD_BITS    (WORD_BITS)
    ) u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    // Output register pair: lets the back run while a word waits
    hse_queue #(
        .WIDTH ($bits(hse_pkg::result_t)),
        .DEPTH (hse_pkg::RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .full  (res_full),
        .level (res_level)
    );

    // Front credit check must keep the command queue from overflowing
    a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue overflow");

    // Words only come out of a consumed command
    a_res_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> cmd_pop)
        else $error("result without command");

    // Back never pushes into a full result queue
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_level != RES_CW'(hse_pkg::RES_DEPTH)))
        else $error("result queue overflow");

    // An accepted item takes at most one slot: from an empty queue, level grows by one at most
    a_cmd_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_level == CMD_CW'(0)) |=> (cmd_level <= CMD_CW'(1)))
        else $error("command queue level jumped");

endmodule

`default_nettype wire
